/* hdl/sas_pkg.sv */
`default_nettype none

package sas_pkg;

	// table sizes
	localparam int NUM_STATES            = 16;
	localparam int TRANSITIONS_PER_STATE = 4;
	localparam int NUM_CONDITIONS        = 8;

	localparam int ST_W      = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int TADDR_W   = $clog2(NUM_STATES * TRANSITIONS_PER_STATE);
	localparam int NTRANS_W  = $clog2(TRANSITIONS_PER_STATE + 1);
	localparam int TRANS_NUM = NUM_STATES * TRANSITIONS_PER_STATE;

	// field widths fixed by the request format
	localparam int IDX_W   = 4;
	localparam int ACC_W   = 17;
	localparam int FRAME_W = 8;
	localparam int COUNT_W = 9;

	// request opcodes
	localparam logic [1:0] OP_TICK        = 2'd0;
	localparam logic [1:0] OP_WRITE_STATE = 2'd1;
	localparam logic [1:0] OP_WRITE_TRANS = 2'd2;
	localparam logic [1:0] OP_FORCE       = 2'd3;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] time_value;
		logic [7:0]  conditions;
		logic [3:0]  state_index;
		logic [11:0] frame_start;
		logic [8:0]  frame_count;
		logic        loop_flag;
		logic        reverse_flag;
		logic [2:0]  slot;
		logic [3:0]  target_state;
		logic [2:0]  cond_index;
		logic        invert_flag;
	} sas_req_t;

	typedef struct packed {
		logic        active;
		logic [3:0]  current_state;
		logic [12:0] frame_index;
		logic [7:0]  frame_number;
		logic        done_res;
		logic        frame_changed;
	} sas_rsp_t;

	// one transition entry as held in the transition memory
	typedef struct packed {
		logic       invert;
		logic [2:0] cond;
		logic [3:0] target;
	} sas_trans_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic apply;
		logic slot_clr;
		logic rd_issue;
		logic take;
		logic slot_inc;
		logic step;
		logic load_out;
	} sas_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       active;
		logic       slot_in_use;
		logic       guard_hit;
		logic       out_free;
	} sas_status_t;

endpackage

`default_nettype wire

/* hdl/sas_ctrl.sv */
`default_nettype none

module sas_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire sas_pkg::sas_status_t status,
	output sas_pkg::sas_cmd_t        cmd
);
	import sas_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_EVAL   = 3'd3;
	localparam logic [2:0] S_STEP   = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_ready = (state_q == S_IDLE);

	// sequencing of one request
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				if (status.op == OP_TICK) begin
					if (status.active) begin
						cmd.slot_clr = 1'b1;
						state_d      = S_SCAN;
					end else begin
						state_d = S_FINISH;
					end
				end else begin
					cmd.apply = 1'b1;
					state_d   = S_FINISH;
				end
			end
			S_SCAN: begin
				if (status.slot_in_use) begin
					cmd.rd_issue = 1'b1;
					state_d      = S_EVAL;
				end else begin
					state_d = S_STEP;
				end
			end
			S_EVAL: begin
				if (status.guard_hit) begin
					cmd.take = 1'b1;
					state_d  = S_STEP;
				end else begin
					cmd.slot_inc = 1'b1;
					state_d      = S_SCAN;
				end
			end
			S_STEP: begin
				cmd.step = 1'b1;
				state_d  = S_FINISH;
			end
			S_FINISH: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef NO_ASSERTIONS
	// a request is taken only when the previous one has fully finished
	a_latch_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |=> (state_q == S_EXEC))
		else $error("request latched outside idle");

	// the transition scan always reads before it evaluates
	a_eval_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL) |-> $past(cmd.rd_issue))
		else $error("evaluation without transition read");

	// a result is only loaded when the output register is free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> status.out_free)
		else $error("result loaded over a pending one");
`endif

endmodule

`default_nettype wire

/* hdl/sas_datapath.sv */
`default_nettype none

module sas_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sas_pkg::sas_req_t   req,
	input  wire sas_pkg::sas_cmd_t   cmd,
	output sas_pkg::sas_status_t     status,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output sas_pkg::sas_rsp_t        rsp
);
	import sas_pkg::*;

	// latched request
	sas_req_t req_q;

	// state table: valid bits reset, entries written before use
	logic [NUM_STATES-1:0]    st_valid_q;
	logic [11:0]              st_start_q  [NUM_STATES];
	logic [COUNT_W-1:0]       st_count_q  [NUM_STATES];
	logic                     st_loop_q   [NUM_STATES];
	logic                     st_rev_q    [NUM_STATES];
	logic [15:0]              st_period_q [NUM_STATES];
	logic [NTRANS_W-1:0]      st_ntrans_q [NUM_STATES];

	// transition memory
	sas_trans_t               trans_mem [TRANS_NUM];
	sas_trans_t               trans_rd_q;

	// sequencer state
	logic [IDX_W-1:0]         cur_q;
	logic                     cur_valid_q;
	logic [FRAME_W-1:0]       pos_q;
	logic                     done_q;
	logic [ACC_W-1:0]         acc_q;
	logic                     changed_q;
	logic [NTRANS_W-1:0]      slot_q;

	logic                     rsp_valid_q;
	sas_rsp_t                 rsp_q;

	// current state entry
	logic [ST_W-1:0]          cur_st;
	logic [11:0]              cur_start;
	logic [COUNT_W-1:0]       cur_count;
	logic                     cur_loop;
	logic                     cur_rev;
	logic [15:0]              cur_period;
	logic [NTRANS_W-1:0]      cur_ntrans;

	// request decode
	logic                     sidx_ok;
	logic [ST_W-1:0]          sidx_st;
	logic [COUNT_W-1:0]       count_sat;
	logic [NTRANS_W-1:0]      ntrans_sat;
	logic                     slot_ok;
	logic [TADDR_W-1:0]       wr_addr;
	logic [TADDR_W-1:0]       rd_addr;

	// guard and state entry
	logic                     flag;
	logic [IDX_W-1:0]         enter_idx;
	logic                     enter_ok;
	logic                     enter_req;

	// frame step
	logic [ACC_W-1:0]         acc_sum;
	logic [FRAME_W-1:0]       pos_next;
	logic                     done_next;

	assign cur_st     = ST_W'(cur_q);
	assign cur_start  = st_start_q[cur_st];
	assign cur_count  = st_count_q[cur_st];
	assign cur_loop   = st_loop_q[cur_st];
	assign cur_rev    = st_rev_q[cur_st];
	assign cur_period = st_period_q[cur_st];
	assign cur_ntrans = st_ntrans_q[cur_st];

	assign sidx_ok = (32'(req_q.state_index) < NUM_STATES);
	assign sidx_st = ST_W'(req_q.state_index);
	assign slot_ok = (32'(req_q.slot) < TRANSITIONS_PER_STATE);

	// frame count and transitions in use are clamped on write
	always_comb begin
		if (req_q.frame_count == '0) begin
			count_sat = COUNT_W'(1);
		end else if (req_q.frame_count > COUNT_W'(256)) begin
			count_sat = COUNT_W'(256);
		end else begin
			count_sat = req_q.frame_count;
		end
		if (32'(req_q.slot) > TRANSITIONS_PER_STATE) begin
			ntrans_sat = NTRANS_W'(TRANSITIONS_PER_STATE);
		end else begin
			ntrans_sat = NTRANS_W'(req_q.slot);
		end
	end

	assign wr_addr = TADDR_W'(32'(req_q.state_index) * TRANSITIONS_PER_STATE
		+ 32'(req_q.slot));
	assign rd_addr = TADDR_W'(32'(cur_q) * TRANSITIONS_PER_STATE + 32'(slot_q));

	// guard of the transition just read
	assign flag = (32'(trans_rd_q.cond) < NUM_CONDITIONS)
		&& req_q.conditions[trans_rd_q.cond];

	// target of a taken transition or of a forced entry
	assign enter_idx = cmd.take ? trans_rd_q.target : req_q.state_index;
	assign enter_req = cmd.take || (cmd.apply && (req_q.opcode == OP_FORCE));
	assign enter_ok  = (32'(enter_idx) < NUM_STATES)
		&& st_valid_q[ST_W'(enter_idx)]
		&& !(cur_valid_q && (enter_idx == cur_q));

	// frame step of the current state
	assign acc_sum = acc_q + ACC_W'(req_q.time_value);
	always_comb begin
		pos_next  = pos_q;
		done_next = done_q;
		if (cur_rev) begin
			if (pos_q == '0) begin
				if (cur_loop) begin
					pos_next = FRAME_W'(cur_count - COUNT_W'(1));
				end else begin
					done_next = 1'b1;
				end
			end else begin
				pos_next = pos_q - FRAME_W'(1);
			end
		end else begin
			if ((COUNT_W'(pos_q) + COUNT_W'(1)) >= cur_count) begin
				if (cur_loop) begin
					pos_next = '0;
				end else begin
					done_next = 1'b1;
				end
			end else begin
				pos_next = pos_q + FRAME_W'(1);
			end
		end
	end

	assign status.op          = req_q.opcode;
	assign status.active      = cur_valid_q;
	assign status.slot_in_use = (slot_q < cur_ntrans);
	assign status.guard_hit   = (flag != trans_rd_q.invert);
	assign status.out_free    = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// request register
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req;
		end
	end

	// state table entries
	always_ff @(posedge clk) begin
		if (cmd.apply && (req_q.opcode == OP_WRITE_STATE) && sidx_ok) begin
			st_start_q[sidx_st]  <= req_q.frame_start;
			st_count_q[sidx_st]  <= count_sat;
			st_loop_q[sidx_st]   <= req_q.loop_flag;
			st_rev_q[sidx_st]    <= req_q.reverse_flag;
			st_period_q[sidx_st] <= req_q.time_value;
			st_ntrans_q[sidx_st] <= ntrans_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_valid_q <= '0;
		end else if (cmd.apply && (req_q.opcode == OP_WRITE_STATE) && sidx_ok) begin
			st_valid_q[sidx_st] <= 1'b1;
		end
	end

	// transition memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.apply && (req_q.opcode == OP_WRITE_TRANS) && sidx_ok && slot_ok) begin
			trans_mem[wr_addr] <= '{invert: req_q.invert_flag,
				cond: req_q.cond_index, target: req_q.target_state};
		end
		if (cmd.rd_issue) begin
			trans_rd_q <= trans_mem[rd_addr];
		end
	end

	// transition slot counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (cmd.slot_clr) begin
			slot_q <= '0;
		end else if (cmd.slot_inc) begin
			slot_q <= slot_q + NTRANS_W'(1);
		end
	end

	// current state, position, done and time accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			cur_valid_q <= 1'b0;
			pos_q       <= '0;
			done_q      <= 1'b0;
			acc_q       <= '0;
			changed_q   <= 1'b0;
		end else begin
			if (cmd.latch) begin
				changed_q <= 1'b0;
			end
			if (enter_req && enter_ok) begin
				cur_q       <= enter_idx;
				cur_valid_q <= 1'b1;
				pos_q       <= '0;
				done_q      <= 1'b0;
				acc_q       <= '0;
			end
			if (cmd.step) begin
				if (acc_sum > ACC_W'(cur_period)) begin
					pos_q     <= pos_next;
					done_q    <= done_next;
					acc_q     <= '0;
					changed_q <= (pos_next != pos_q);
				end else begin
					acc_q <= acc_sum;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (cur_valid_q) begin
				rsp_q.active        <= 1'b1;
				rsp_q.current_state <= cur_q;
				rsp_q.frame_index   <= 13'(cur_start) + 13'(pos_q);
				rsp_q.frame_number  <= pos_q;
				rsp_q.done_res      <= done_q;
				rsp_q.frame_changed <= changed_q;
			end else begin
				rsp_q <= '0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// nothing moves until a state has been entered
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!cur_valid_q |-> (pos_q == '0) && !done_q && (acc_q == '0))
		else $error("animation state moved while inactive");

	// the current state always names a written table entry
	a_cur_written: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> st_valid_q[cur_st])
		else $error("current state not in table");

	// a changed frame is only ever reported for an active state
	a_changed_active: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.frame_changed) |-> rsp_q.active)
		else $error("frame change reported while inactive");

	// a state entry and a frame step never fall in the same cycle
	a_enter_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(enter_req && cmd.step))
		else $error("state entry collides with frame step");
`endif

endmodule

`default_nettype wire

/* hdl/sprite_animation_sequencer.sv */
`default_nettype none

// Sprite animation sequencer: each request is a tick, a state-table write,
// a transition write or a forced state entry, and yields exactly one response
// with the current state, frame and done status. Requests are handled one at
// a time. A tick with an entered state scans the transitions in use of the
// current state in slot order, reading one slot of the transition memory and
// then evaluating its guard, and stops at the first slot whose guard holds;
// it then steps the frame. A new request is taken while the previous response
// still waits in the output register. No clearing pass is needed after reset.
module sprite_animation_sequencer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire sas_pkg::sas_req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output sas_pkg::sas_rsp_t      rsp
);
	import sas_pkg::*;

	sas_cmd_t    cmd;
	sas_status_t status;

	// sequencing state machine
	sas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// tables, animation state and result register
	sas_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

/* dv/sprite_animation_sequencer_tb.sv */
`timescale 1ns / 100ps

module sprite_animation_sequencer_tb;
	import sas_pkg::*;

	localparam int RANDOM_REQUESTS = 750;
	localparam int STALL_LIMIT     = 2000;
	localparam int DRAIN_CYCLES    = 30;

	// one animation state as the sequencer holds it
	typedef struct packed {
		bit        valid;
		bit [11:0] start;
		bit [8:0]  count;
		bit        loop;
		bit        rev;
		bit [15:0] period;
		bit [2:0]  ntrans;
	} anim_entry_t;

	// one guarded transition
	typedef struct packed {
		bit [3:0] target;
		bit [2:0] cond;
		bit       invert;
	} anim_link_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	sas_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	sas_rsp_t rsp;

	sprite_animation_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted sequencer state
	anim_entry_t anim_tab [NUM_STATES];
	anim_link_t  link_tab [TRANS_NUM];
	bit          link_written [TRANS_NUM];
	bit [3:0]    cur_idx;
	bit          cur_on;
	bit [7:0]    pos;
	bit          at_end;
	bit [16:0]   acc;

	sas_rsp_t expected_status_q [$];
	int       mismatches    = 0;
	int       requests_sent = 0;
	int       idle_cycles   = 0;
	int       send_stretch  = 0;
	int       recv_stretch  = 0;

	// entering a different valid state restarts its animation
	function automatic void enter_state(bit [3:0] idx);
		if (idx >= NUM_STATES || !anim_tab[idx].valid)
			return;
		if (cur_on && idx == cur_idx)
			return;
		cur_idx = idx;
		cur_on  = 1'b1;
		pos     = '0;
		at_end  = 1'b0;
		acc     = '0;
	endfunction

	// one frame step, wrapping or stopping at the end of the count
	function automatic void step_frame();
		anim_entry_t s;
		s = anim_tab[cur_idx];
		if (s.rev) begin
			if (pos == 0) begin
				if (s.loop)
					pos = 8'(s.count - 9'd1);
				else
					at_end = 1'b1;
			end else begin
				pos = pos - 8'd1;
			end
		end else begin
			if (int'(pos) + 1 >= int'(s.count)) begin
				if (s.loop)
					pos = '0;
				else
					at_end = 1'b1;
			end else begin
				pos = pos + 8'd1;
			end
		end
	endfunction

	// transition scan then time accumulation; returns whether the frame moved
	function automatic bit tick_sequencer(bit [15:0] dt, bit [7:0] conds);
		anim_link_t l;
		bit         taken;
		bit         flag;
		bit [7:0]   prev;
		if (!cur_on)
			return 1'b0;
		taken = 1'b0;
		for (int i = 0; i < int'(anim_tab[cur_idx].ntrans) && !taken; i++) begin
			l    = link_tab[int'(cur_idx) * TRANSITIONS_PER_STATE + i];
			flag = (l.cond < NUM_CONDITIONS) ? conds[l.cond] : 1'b0;
			if (flag != l.invert) begin
				taken = 1'b1;
				enter_state(l.target);
			end
		end
		prev = pos;
		acc  = acc + 17'(dt);
		if (acc > 17'(anim_tab[cur_idx].period)) begin
			step_frame();
			acc = '0;
		end
		return pos != prev;
	endfunction

	// apply one accepted request and return the status it should report
	function automatic sas_rsp_t advance_sequencer(sas_req_t r);
		sas_rsp_t o;
		bit       moved;
		int       li;
		moved = 1'b0;
		case (r.opcode)
			OP_TICK: begin
				moved = tick_sequencer(r.time_value, r.conditions);
			end
			OP_WRITE_STATE: begin
				anim_tab[r.state_index].valid  = 1'b1;
				anim_tab[r.state_index].start  = r.frame_start;
				anim_tab[r.state_index].count  = (r.frame_count == 0) ? 9'd1 :
					(r.frame_count > 256) ? 9'd256 : r.frame_count;
				anim_tab[r.state_index].loop   = r.loop_flag;
				anim_tab[r.state_index].rev    = r.reverse_flag;
				anim_tab[r.state_index].period = r.time_value;
				anim_tab[r.state_index].ntrans = (r.slot > TRANSITIONS_PER_STATE) ?
					3'(TRANSITIONS_PER_STATE) : r.slot;
			end
			OP_WRITE_TRANS: begin
				if (r.slot < TRANSITIONS_PER_STATE) begin
					li = int'(r.state_index) * TRANSITIONS_PER_STATE + int'(r.slot);
					link_tab[li]     = '{target: r.target_state, cond: r.cond_index,
						invert: r.invert_flag};
					link_written[li] = 1'b1;
				end
			end
			OP_FORCE: begin
				enter_state(r.state_index);
			end
		endcase
		o = '0;
		if (cur_on) begin
			o.active        = 1'b1;
			o.current_state = cur_idx;
			o.frame_index   = 13'(anim_tab[cur_idx].start) + 13'(pos);
			o.frame_number  = pos;
			o.done_res      = at_end;
			o.frame_changed = moved;
		end
		return o;
	endfunction

	// gap before the next request or response, with runs of back-to-back traffic
	task automatic draw_wait(inout int stretch, output int cycles);
		if (stretch > 0) begin
			stretch--;
			cycles = 0;
		end else if ($urandom_range(0, 15) == 0) begin
			stretch = $urandom_range(8, 40);
			cycles  = 0;
		end else begin
			cycles = $urandom_range(0, 15);
		end
	endtask

	// request builders; unused fields carry random values
	function automatic sas_req_t noise_req();
		sas_req_t r;
		r = {$urandom, $urandom};
		return r;
	endfunction

	function automatic sas_req_t tick_req(bit [15:0] dt, bit [7:0] conds);
		sas_req_t r;
		r            = noise_req();
		r.opcode     = OP_TICK;
		r.time_value = dt;
		r.conditions = conds;
		return r;
	endfunction

	function automatic sas_req_t state_req(bit [3:0] idx, bit [11:0] start, bit [8:0] count,
			bit loop, bit rev, bit [15:0] period, bit [2:0] links);
		sas_req_t r;
		r              = noise_req();
		r.opcode       = OP_WRITE_STATE;
		r.state_index  = idx;
		r.frame_start  = start;
		r.frame_count  = count;
		r.loop_flag    = loop;
		r.reverse_flag = rev;
		r.time_value   = period;
		r.slot         = links;
		return r;
	endfunction

	function automatic sas_req_t link_req(bit [3:0] idx, bit [2:0] slot, bit [3:0] target,
			bit [2:0] cond, bit inv);
		sas_req_t r;
		r              = noise_req();
		r.opcode       = OP_WRITE_TRANS;
		r.state_index  = idx;
		r.slot         = slot;
		r.target_state = target;
		r.cond_index   = cond;
		r.invert_flag  = inv;
		return r;
	endfunction

	function automatic sas_req_t force_req(bit [3:0] idx);
		sas_req_t r;
		r             = noise_req();
		r.opcode      = OP_FORCE;
		r.state_index = idx;
		return r;
	endfunction

	// state index, mostly one that has been written
	function automatic bit [3:0] pick_state();
		bit [3:0] idx;
		idx = 4'($urandom_range(0, NUM_STATES - 1));
		if ($urandom_range(0, 4) != 0)
			repeat (8) if (!anim_tab[idx].valid) idx = 4'($urandom_range(0, NUM_STATES - 1));
		return idx;
	endfunction

	// present one request and hold it until accepted
	task automatic drive_request(input sas_req_t r);
		int gap;
		draw_wait(send_stretch, gap);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_ready !== 1'b1);
		expected_status_q.push_back(advance_sequencer(r));
		requests_sent++;
	endtask

	// a state's in-use slots must hold written transitions before it can scan them
	task automatic send_request(input sas_req_t r);
		int base;
		int need;
		if (r.opcode == OP_WRITE_STATE) begin
			base = int'(r.state_index) * TRANSITIONS_PER_STATE;
			need = (r.slot > TRANSITIONS_PER_STATE) ? TRANSITIONS_PER_STATE : int'(r.slot);
			for (int i = 0; i < need; i++)
				if (!link_written[base + i])
					drive_request(link_req(r.state_index, 3'(i), pick_state(),
						3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
		end
		drive_request(r);
	endtask

	// nothing entered yet: a tick, a force to an unwritten state, an ignored slot
	task automatic test_idle_block();
		send_request(tick_req(16'hFFFF, 8'hFF));
		send_request(force_req(4'd5));
		send_request(link_req(4'd0, 3'd6, 4'd1, 3'd0, 1'b0));
	endtask

	// forward looping, re-force of the current state, shrinking the count under it
	task automatic test_frame_stepping();
		send_request(state_req(4'd1, 12'hFFF, 9'd3, 1'b1, 1'b0, 16'd0, 3'd0));
		send_request(force_req(4'd1));
		repeat (4) send_request(tick_req(16'd1, 8'h00));
		send_request(force_req(4'd1));
		send_request(state_req(4'd1, 12'hFFF, 9'd1, 1'b0, 1'b0, 16'd0, 3'd0));
		send_request(tick_req(16'd1, 8'h00));
		send_request(tick_req(16'd0, 8'h00));
	endtask

	// reverse stepping, zero and oversized counts, the largest period
	task automatic test_reverse_and_counts();
		send_request(state_req(4'd2, 12'h000, 9'd0, 1'b0, 1'b1, 16'hFFFF, 3'd0));
		send_request(force_req(4'd2));
		send_request(tick_req(16'hFFFF, 8'h00));
		send_request(tick_req(16'd1, 8'h00));
		send_request(state_req(4'd3, 12'd100, 9'd511, 1'b1, 1'b1, 16'd16, 3'd0));
		send_request(force_req(4'd3));
		send_request(tick_req(16'd17, 8'h00));
		send_request(tick_req(16'hFFFF, 8'h00));
	endtask

	// guard scan: invalid target, same target, inverted guard, first hit wins
	task automatic test_transition_scan();
		send_request(link_req(4'd3, 3'd0, 4'd15, 3'd7, 1'b0));
		send_request(link_req(4'd3, 3'd1, 4'd3, 3'd0, 1'b1));
		send_request(link_req(4'd3, 3'd2, 4'd1, 3'd5, 1'b0));
		send_request(link_req(4'd3, 3'd3, 4'd2, 3'd0, 1'b0));
		send_request(state_req(4'd3, 12'd100, 9'd256, 1'b1, 1'b1, 16'd16, 3'd7));
		send_request(tick_req(16'd3, 8'h80));
		send_request(tick_req(16'd3, 8'h01));
	endtask

	// episodes of state setup, wiring, entry and a run of ticks, with noise mixed in
	task automatic test_random_sequences();
		int        stop_at;
		bit [15:0] p;
		bit [15:0] dt;
		bit [7:0]  conds;
		bit [8:0]  count;
		bit [15:0] period;
		stop_at = requests_sent + RANDOM_REQUESTS;
		while (requests_sent < stop_at) begin
			repeat ($urandom_range(1, 4)) begin
				count  = ($urandom_range(0, 4) != 0) ? 9'($urandom_range(1, 8)) :
					9'($urandom_range(0, 511));
				case ($urandom_range(0, 9))
					0:       period = 16'($urandom);
					1, 2:    period = 16'($urandom_range(0, 300));
					default: period = 16'($urandom_range(0, 3));
				endcase
				send_request(state_req(pick_state(), 12'($urandom), count,
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), period,
					3'($urandom_range(0, 7))));
			end
			repeat ($urandom_range(0, 6))
				send_request(link_req(pick_state(),
					3'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 3)),
					($urandom_range(0, 4) == 0) ? 4'($urandom) : pick_state(),
					3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
			send_request(force_req(pick_state()));
			repeat ($urandom_range(5, 30)) begin
				if ($urandom_range(0, 9) == 0) begin
					send_request(noise_req());
				end else begin
					p = anim_tab[cur_idx].period;
					case ($urandom_range(0, 9))
						0:       dt = 16'd0;
						1:       dt = 16'hFFFF;
						2, 3:    dt = 16'($urandom);
						default: dt = 16'($urandom_range(0, (p > 16'd32767) ? 65535 : 2 * p + 1));
					endcase
					conds = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
					send_request(tick_req(dt, conds));
				end
			end
		end
	endtask

	// response side stalls
	initial begin : rsp_stall
		int hold;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			draw_wait(recv_stretch, hold);
			if (hold > 0) begin
				rsp_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!(rsp_valid === 1'b1 && rsp_ready === 1'b1));
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// compare each response with the oldest prediction
	always @(posedge clk) begin : rsp_check
		sas_rsp_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
			if (expected_status_q.size() == 0) begin
				mismatches++;
				$display("%0t: response with no request outstanding, expected none, got %p",
					$time, rsp);
			end else begin
				want = expected_status_q.pop_front();
				check_field("active", want.active, rsp.active);
				check_field("current_state", want.current_state, rsp.current_state);
				check_field("frame_index", want.frame_index, rsp.frame_index);
				check_field("frame_number", want.frame_number, rsp.frame_number);
				check_field("done_res", want.done_res, rsp.done_res);
				check_field("frame_changed", want.frame_changed, rsp.frame_changed);
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("** sprite_animation_sequencer: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_block();
		test_frame_stepping();
		test_reverse_and_counts();
		test_transition_scan();
		test_random_sequences();
		req_valid <= 1'b0;
		while (expected_status_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("** sprite_animation_sequencer: PASSED **");
		else
			$display("** sprite_animation_sequencer: FAILED **");
		$finish;
	end

endmodule
